FILE: hdl/cscc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Current sense conditioner package
// Shared types, request and register codes and datapath widths.
// ----------------------------------------------------------------------------
package cscc_pkg;

    // Request codes carried in the req_type field.
    typedef enum logic [1:0] {
        REQ_SAMPLE    = 2'd0,
        REQ_CLR_ONE   = 2'd1,
        REQ_CLR_ALL   = 2'd2,
        REQ_UNDEFINED = 2'd3
    } req_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_OFFSET_RAW  = 3'd0,
        REG_GAIN_FACTOR = 3'd1,
        REG_SENSITIVITY = 3'd2,
        REG_CUR_LIMIT   = 3'd3,
        REG_ZERO_MV     = 3'd4,
        REG_REFERENCE   = 3'd5,
        REG_CAL_VALID   = 3'd6,
        REG_UNUSED      = 3'd7
    } reg_idx_t;

    // Conversion sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WIN,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_MUL_REF,
        ST_DFS_GO,
        ST_DFS_WAIT,
        ST_MUL_K,
        ST_DSN_GO,
        ST_DSN_WAIT,
        ST_MUL_GAIN,
        ST_SAT,
        ST_STATS,
        ST_DONE
    } state_t;

    // Serial divider widths: dividend and divisor.
    localparam int DIV_W   = 28;
    localparam int DVS_W   = 16;
    // Datapath widths.
    localparam int SMP_W   = 12;
    localparam int CFG_W   = 26;
    localparam int PROD_W  = 29;
    localparam int MV_W    = 19;
    localparam int MA_W    = 29;
    localparam int GPROD_W = 48;
    localparam int CUR_W   = 27;
    localparam int STAT_W  = 32;
    localparam int SUMS_W  = 64;
    localparam int MA_SCALE = 1000;
    localparam int Q_SHIFT  = 16;

endpackage

FILE: hdl/cscc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cscc_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [cscc_pkg::DIV_W-1:0] dividend,
    input  logic [cscc_pkg::DVS_W-1:0] divisor,
    output logic                       done,
    output logic [cscc_pkg::DIV_W-1:0] quotient
);
    import cscc_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DVS_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]    quo_reg, quo_next;
    logic [DVS_W-1:0]    dvs_reg, dvs_next;
    logic [DVS_W:0]      trial;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = DVS_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DVS_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hdl/cscc_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average window
// Per-channel sample ring in a memory with running sum, fill and pointer.
// ----------------------------------------------------------------------------
module cscc_window #(
    parameter int CHANNELS = 16,
    parameter int WINDOW   = 8,
    parameter int CH_W     = 4,
    parameter int FILL_W   = 4,
    parameter int SUM_W    = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [CH_W-1:0]               ch_idx,
    input  logic [cscc_pkg::SMP_W-1:0]    raw,
    output logic                          done,
    output logic [SUM_W-1:0]              sum_out,
    output logic [FILL_W-1:0]             fill_out
);
    import cscc_pkg::*;

    localparam int DEPTH  = CHANNELS * WINDOW;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    logic [SMP_W-1:0]  mem [DEPTH];
    logic [SUM_W-1:0]  sum_reg  [CHANNELS];
    logic [FILL_W-1:0] fill_reg [CHANNELS];
    logic [PTR_W-1:0]  ptr_reg  [CHANNELS];

    logic              busy_reg;
    logic              done_reg;
    logic [CH_W-1:0]   idx_reg;
    logic [SMP_W-1:0]  raw_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [SMP_W-1:0]  rd_reg;
    logic [SUM_W-1:0]  sum_out_reg;
    logic [FILL_W-1:0] fill_out_reg;

    logic [ADDR_W-1:0] addr;
    logic [SMP_W-1:0]  old_smp;
    logic [SUM_W-1:0]  sum_new;
    logic              full;

    // Ring address of the slot that the new sample replaces.
    assign addr = ADDR_W'(ADDR_W'(ch_idx) * ADDR_W'(WINDOW)) + ADDR_W'(ptr_reg[ch_idx]);

    // Slots past the fill level were never written and count as zero.
    assign full    = (fill_reg[idx_reg] == FILL_W'(WINDOW));
    assign old_smp = full ? rd_reg : '0;
    assign sum_new = sum_reg[idx_reg] - SUM_W'(old_smp) + SUM_W'(raw_reg);

    // Ring memory: read on start, write back in the following cycle.
    always_ff @(posedge aclk) begin
        if (start) begin
            rd_reg <= mem[addr];
        end
        if (busy_reg) begin
            mem[addr_reg] <= raw_reg;
        end
    end

    // Per-channel sum, fill and pointer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                sum_reg[c]  <= '0;
                fill_reg[c] <= '0;
                ptr_reg[c]  <= '0;
            end
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                busy_reg         <= 1'b0;
                done_reg         <= 1'b1;
                sum_reg[idx_reg] <= sum_new;
                if (!full) begin
                    fill_reg[idx_reg] <= fill_reg[idx_reg] + 1'b1;
                end
                if (ptr_reg[idx_reg] == PTR_W'(WINDOW - 1)) begin
                    ptr_reg[idx_reg] <= '0;
                end else begin
                    ptr_reg[idx_reg] <= ptr_reg[idx_reg] + 1'b1;
                end
            end
        end
    end

    // Captured item and results.
    always_ff @(posedge aclk) begin
        if (start) begin
            idx_reg  <= ch_idx;
            raw_reg  <= raw;
            addr_reg <= addr;
        end
        if (busy_reg) begin
            sum_out_reg  <= sum_new;
            fill_out_reg <= full ? fill_reg[idx_reg] : fill_reg[idx_reg] + 1'b1;
        end
    end

    assign done     = done_reg;
    assign sum_out  = sum_out_reg;
    assign fill_out = fill_out_reg;

endmodule

FILE: hdl/current_sense_channel_conditioner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Current sense channel conditioner
// Moving average, millivolt and milliamp conversion, Q16 gain and statistics.
// ----------------------------------------------------------------------------
// Usage:
// A word on the s_ channel is a request: a sample, a clear of one channel's
// statistics or a clear of all. Each accepted request that is not ignored
// yields one word on the m_ channel with the converted current and the
// channel's statistics after the request. Unknown requests, and samples or
// single clears of a channel at or above CHANNELS, give no word.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wr_data while
// the block is idle; writes take effect at once.
// A sample's result word is registered after the window update and the
// bit-serial divider, which the averaging, full-scale and sensitivity
// divisions share in turn; with calibration off only the averaging one runs.
// A clear goes straight to the done state and its word is registered once
// the output register is free. One request is in work at a time and s_ready
// returns with the result, so no new request is taken until that is registered.
// The result word sits in an output register: if the receiver stalls, the next
// request is still accepted and worked, then waits with s_ready low.
// Reset clears all statistics, the windows and the registers to their defaults.
// ----------------------------------------------------------------------------
module current_sense_channel_conditioner_core #(
    parameter int CHANNELS       = 16,
    parameter int WINDOW         = 8,
    parameter int ADC_FULL_SCALE = 4095
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Configuration port
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_index,
    input  logic [25:0]         cfg_wr_data,
    // Request channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_req_type,
    input  logic [3:0]          s_channel,
    input  logic [11:0]         s_raw_sample,
    // Result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [3:0]          m_channel_out,
    output logic signed [26:0]  m_current_milliamps,
    output logic [11:0]         m_filtered_raw,
    output logic                m_overcurrent,
    output logic signed [31:0]  m_min_current_milliamps,
    output logic signed [31:0]  m_max_current_milliamps,
    output logic [31:0]         m_sample_count,
    output logic signed [63:0]  m_current_sum_ma,
    output logic [31:0]         m_overcurrent_count
);
    import cscc_pkg::*;

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = SMP_W + FILL_W;
    localparam logic signed [31:0] STAT_MIN_INIT = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] STAT_MAX_INIT = 32'sh8000_0000;
    localparam logic signed [31:0] CUR_MAX = 32'sd67108863;
    localparam logic signed [31:0] CUR_MIN = -32'sd67108864;

    // Configuration registers.
    logic [11:0] offset_reg;
    logic [17:0] gain_reg;
    logic [9:0]  sens_reg;
    logic [25:0] limit_reg;
    logic [12:0] zero_reg;
    logic [12:0] ref_reg;
    logic        calv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= 12'd0;
            gain_reg   <= 18'd65536;
            sens_reg   <= 10'd4;
            limit_reg  <= 26'd500000;
            zero_reg   <= 13'd1650;
            ref_reg    <= 13'd3300;
            calv_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_index))
                REG_OFFSET_RAW:  offset_reg <= cfg_wr_data[11:0];
                REG_GAIN_FACTOR: gain_reg   <= cfg_wr_data[17:0];
                REG_SENSITIVITY: sens_reg   <= cfg_wr_data[9:0];
                REG_CUR_LIMIT:   limit_reg  <= cfg_wr_data[25:0];
                REG_ZERO_MV:     zero_reg   <= cfg_wr_data[12:0];
                REG_REFERENCE:   ref_reg    <= cfg_wr_data[12:0];
                REG_CAL_VALID:   calv_reg   <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer state and datapath registers.
    state_t                    state_reg, state_next;
    logic [CH_W-1:0]           idx_reg;
    logic [3:0]                chan_reg;
    logic [SMP_W-1:0]          avg_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      neg_reg;
    logic signed [MV_W-1:0]    mv_reg;
    logic signed [MA_W-1:0]    ma_reg;
    logic signed [GPROD_W-1:0] gprod_reg;
    logic signed [CUR_W-1:0]   cur_reg;
    logic                      oc_reg;

    // Statistics per channel.
    logic [STAT_W-1:0]        st_cnt_reg [CHANNELS];
    logic [SUMS_W-1:0]        st_sum_reg [CHANNELS];
    logic signed [STAT_W-1:0] st_min_reg [CHANNELS];
    logic signed [STAT_W-1:0] st_max_reg [CHANNELS];
    logic [STAT_W-1:0]        st_oc_reg  [CHANNELS];

    // Output register.
    logic                     m_valid_reg;
    logic [3:0]               m_chan_reg;
    logic signed [CUR_W-1:0]  m_cur_reg;
    logic [SMP_W-1:0]         m_filt_reg;
    logic                     m_oc_reg;
    logic signed [STAT_W-1:0] m_min_reg;
    logic signed [STAT_W-1:0] m_max_reg;
    logic [STAT_W-1:0]        m_cnt_reg;
    logic [SUMS_W-1:0]        m_sum_reg;
    logic [STAT_W-1:0]        m_occ_reg;

    // Request decode.
    logic            accept;
    logic            ch_ok;
    logic [CH_W-1:0] in_idx;
    req_t            req;

    assign req     = req_t'(s_req_type);
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign ch_ok   = (32'(s_channel) < CHANNELS);
    assign in_idx  = CH_W'(s_channel);

    // Shared divider and window.
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic             div_done;
    logic [DIV_W-1:0] div_quo;
    logic             win_start;
    logic             win_done;
    logic [SUM_W-1:0] win_sum;
    logic [FILL_W-1:0] win_fill;

    cscc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    cscc_window #(
        .CHANNELS (CHANNELS),
        .WINDOW   (WINDOW),
        .CH_W     (CH_W),
        .FILL_W   (FILL_W),
        .SUM_W    (SUM_W)
    ) u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (win_start),
        .ch_idx   (in_idx),
        .raw      (s_raw_sample),
        .done     (win_done),
        .sum_out  (win_sum),
        .fill_out (win_fill)
    );

    // Intermediate values of the conversion.
    logic signed [13:0]       cal;
    logic [PROD_W-1:0]        prod_mag;
    logic [DVS_W-1:0]         sens_eff;
    logic signed [PROD_W:0]   mv_full;
    logic signed [MA_W-1:0]   q_signed;
    logic signed [31:0]       g_shift;
    logic signed [31:0]       cur_ext;
    logic signed [27:0]       lim_pos;
    logic                     out_free;

    assign cal      = $signed({2'b00, avg_reg}) - $signed({2'b00, offset_reg});
    assign prod_mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign sens_eff = (sens_reg == 10'd0) ? DVS_W'(1) : DVS_W'(sens_reg);
    assign q_signed = neg_reg ? -$signed(MA_W'(div_quo)) : $signed(MA_W'(div_quo));
    assign mv_full  = (PROD_W + 1)'(q_signed) - $signed({{(PROD_W - 13){1'b0}}, zero_reg});
    assign g_shift  = 32'(gprod_reg >>> Q_SHIFT);
    assign cur_ext  = 32'(cur_reg);
    assign lim_pos  = $signed({2'b00, limit_reg});
    assign out_free = !m_valid_reg || m_ready;

    // Next state and unit strobes.
    always_comb begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = DVS_W'(1);
        win_start    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    priority if (req == REQ_CLR_ALL) begin
                        state_next = ST_DONE;
                    end else if (req == REQ_UNDEFINED || !ch_ok) begin
                        state_next = ST_IDLE;
                    end else if (req == REQ_CLR_ONE) begin
                        state_next = ST_DONE;
                    end else begin
                        win_start  = 1'b1;
                        state_next = ST_WIN;
                    end
                end
            end
            ST_WIN: begin
                if (win_done) state_next = ST_AVG_GO;
            end
            ST_AVG_GO: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(win_sum);
                div_divisor  = DVS_W'(win_fill);
                state_next   = ST_AVG_WAIT;
            end
            ST_AVG_WAIT: begin
                if (div_done) state_next = calv_reg ? ST_MUL_REF : ST_STATS;
            end
            ST_MUL_REF: state_next = ST_DFS_GO;
            ST_DFS_GO: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(prod_mag);
                div_divisor  = DVS_W'(ADC_FULL_SCALE);
                state_next   = ST_DFS_WAIT;
            end
            ST_DFS_WAIT: begin
                if (div_done) state_next = ST_MUL_K;
            end
            ST_MUL_K: state_next = ST_DSN_GO;
            ST_DSN_GO: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(prod_mag);
                div_divisor  = sens_eff;
                state_next   = ST_DSN_WAIT;
            end
            ST_DSN_WAIT: begin
                if (div_done) state_next = ST_MUL_GAIN;
            end
            ST_MUL_GAIN: state_next = ST_SAT;
            ST_SAT:      state_next = ST_STATS;
            ST_STATS:    state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Conversion datapath, one operation per state.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                chan_reg <= s_channel;
                idx_reg  <= (req == REQ_CLR_ALL) ? '0 : in_idx;
                avg_reg  <= '0;
                cur_reg  <= '0;
                oc_reg   <= 1'b0;
            end
            ST_AVG_WAIT: begin
                if (div_done) begin
                    avg_reg <= div_quo[SMP_W-1:0];
                end
            end
            ST_MUL_REF: begin
                prod_reg <= PROD_W'(cal) * PROD_W'($signed({1'b0, ref_reg}));
            end
            ST_DFS_GO, ST_DSN_GO: begin
                neg_reg <= prod_reg[PROD_W-1];
            end
            ST_DFS_WAIT: begin
                if (div_done) begin
                    mv_reg <= MV_W'(mv_full);
                end
            end
            ST_MUL_K: begin
                prod_reg <= PROD_W'(mv_reg) * PROD_W'(MA_SCALE);
            end
            ST_DSN_WAIT: begin
                if (div_done) begin
                    ma_reg <= q_signed;
                end
            end
            ST_MUL_GAIN: begin
                gprod_reg <= GPROD_W'(ma_reg) * GPROD_W'($signed({1'b0, gain_reg}));
            end
            ST_SAT: begin
                priority if (g_shift > CUR_MAX) begin
                    cur_reg <= CUR_W'(CUR_MAX);
                end else if (g_shift < CUR_MIN) begin
                    cur_reg <= CUR_W'(CUR_MIN);
                end else begin
                    cur_reg <= CUR_W'(g_shift);
                end
            end
            ST_STATS: begin
                oc_reg <= ($signed({cur_reg[CUR_W-1], cur_reg}) > lim_pos) ||
                          ($signed({cur_reg[CUR_W-1], cur_reg}) < -lim_pos);
            end
            default: ;
        endcase
    end

    // Statistics update and clears.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                st_cnt_reg[c] <= '0;
                st_sum_reg[c] <= '0;
                st_min_reg[c] <= STAT_MIN_INIT;
                st_max_reg[c] <= STAT_MAX_INIT;
                st_oc_reg[c]  <= '0;
            end
        end else if (accept && req == REQ_CLR_ALL) begin
            for (int c = 0; c < CHANNELS; c++) begin
                st_cnt_reg[c] <= '0;
                st_sum_reg[c] <= '0;
                st_min_reg[c] <= STAT_MIN_INIT;
                st_max_reg[c] <= STAT_MAX_INIT;
                st_oc_reg[c]  <= '0;
            end
        end else if (accept && req == REQ_CLR_ONE && ch_ok) begin
            st_cnt_reg[in_idx] <= '0;
            st_sum_reg[in_idx] <= '0;
            st_min_reg[in_idx] <= STAT_MIN_INIT;
            st_max_reg[in_idx] <= STAT_MAX_INIT;
            st_oc_reg[in_idx]  <= '0;
        end else if (state_reg == ST_STATS) begin
            st_cnt_reg[idx_reg] <= st_cnt_reg[idx_reg] + 1'b1;
            st_sum_reg[idx_reg] <= st_sum_reg[idx_reg] + SUMS_W'(cur_ext);
            if (cur_ext < st_min_reg[idx_reg]) begin
                st_min_reg[idx_reg] <= cur_ext;
            end
            if (cur_ext > st_max_reg[idx_reg]) begin
                st_max_reg[idx_reg] <= cur_ext;
            end
            if ((32'(cur_ext) != 32'(0)) &&
                (($signed({cur_reg[CUR_W-1], cur_reg}) > lim_pos) ||
                 ($signed({cur_reg[CUR_W-1], cur_reg}) < -lim_pos))) begin
                st_oc_reg[idx_reg] <= st_oc_reg[idx_reg] + 1'b1;
            end
        end
    end

    // Result word register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_chan_reg <= chan_reg;
            m_cur_reg  <= cur_reg;
            m_filt_reg <= avg_reg;
            m_oc_reg   <= oc_reg;
            m_min_reg  <= st_min_reg[idx_reg];
            m_max_reg  <= st_max_reg[idx_reg];
            m_cnt_reg  <= st_cnt_reg[idx_reg];
            m_sum_reg  <= st_sum_reg[idx_reg];
            m_occ_reg  <= st_oc_reg[idx_reg];
        end
    end

    assign m_valid                 = m_valid_reg;
    assign m_channel_out           = m_chan_reg;
    assign m_current_milliamps     = m_cur_reg;
    assign m_filtered_raw          = m_filt_reg;
    assign m_overcurrent           = m_oc_reg;
    assign m_min_current_milliamps = m_min_reg;
    assign m_max_current_milliamps = m_max_reg;
    assign m_sample_count          = m_cnt_reg;
    assign m_current_sum_ma        = $signed(m_sum_reg);
    assign m_overcurrent_count     = m_occ_reg;

endmodule

FILE: bench/conditioner_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conditioner result checker
// Follows register writes and accepted request words, predicts each result
// word of the current sense conditioner and compares it field by field with
// the word that the block delivers.
// ----------------------------------------------------------------------------
module conditioner_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [25:0]        cfg_wr_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic [3:0]         s_channel,
    input  logic [11:0]        s_raw_sample,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [3:0]         m_channel_out,
    input  logic signed [26:0] m_current_milliamps,
    input  logic [11:0]        m_filtered_raw,
    input  logic               m_overcurrent,
    input  logic signed [31:0] m_min_current_milliamps,
    input  logic signed [31:0] m_max_current_milliamps,
    input  logic [31:0]        m_sample_count,
    input  logic signed [63:0] m_current_sum_ma,
    input  logic [31:0]        m_overcurrent_count,
    output int                 mismatches,
    output int                 readings_due
);
    import cscc_pkg::*;

    localparam int     NCH        = 16;
    localparam int     NWIN       = 8;
    localparam longint FULL_SCALE = 4095;
    localparam longint CUR_HI     = 67108863;
    localparam longint CUR_LO     = -67108864;

    typedef struct {
        logic [3:0]         ch;
        logic signed [26:0] cur;
        logic [11:0]        filt;
        logic               oc;
        logic signed [31:0] mn;
        logic signed [31:0] mx;
        logic [31:0]        cnt;
        logic signed [63:0] sum;
        logic [31:0]        occ;
    } reading_t;

    reading_t readings_q[$];

    // Shadow copy of the configuration registers.
    logic [11:0] cf_offset;
    logic [17:0] cf_gain;
    logic [9:0]  cf_sens;
    logic [25:0] cf_limit;
    logic [12:0] cf_zero;
    logic [12:0] cf_ref;
    logic        cf_cal_valid;

    // Per-channel averaging windows and statistics.
    logic [11:0]        win_mem [NCH][NWIN];
    logic [14:0]        win_acc [NCH];
    logic [3:0]         win_cnt [NCH];
    logic [2:0]         win_ptr [NCH];
    logic [31:0]        st_count [NCH];
    logic signed [63:0] st_sum [NCH];
    logic signed [31:0] st_min [NCH];
    logic signed [31:0] st_max [NCH];
    logic [31:0]        st_oc [NCH];

    assign readings_due = readings_q.size();

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %h wanted %h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic void clear_channel(int c);
        st_count[c] = '0;
        st_sum[c]   = '0;
        st_min[c]   = 32'sh7FFF_FFFF;
        st_max[c]   = 32'sh8000_0000;
        st_oc[c]    = '0;
    endfunction

    // Averaged raw value to milliamps, with gain and saturation; zero while calibration is not valid.
    function automatic longint to_milliamps(logic [11:0] avg);
        longint cal, mv, ma, prod, g, sens;
        if (!cf_cal_valid)
            return 0;
        sens = (cf_sens == 0) ? 1 : longint'(cf_sens);
        cal  = longint'(avg) - longint'(cf_offset);
        mv   = (cal * longint'(cf_ref)) / FULL_SCALE;
        mv   = mv - longint'(cf_zero);
        ma   = (mv * 1000) / sens;
        prod = ma * longint'(cf_gain);
        if (prod >= 0)
            g = prod / 65536;
        else
            g = -((-prod + 65535) / 65536);
        if (g > CUR_HI)
            g = CUR_HI;
        if (g < CUR_LO)
            g = CUR_LO;
        return g;
    endfunction

    function automatic reading_t stats_of(int c, logic [3:0] ch_out);
        reading_t r;
        r.ch   = ch_out;
        r.cur  = '0;
        r.filt = '0;
        r.oc   = 1'b0;
        r.mn   = st_min[c];
        r.mx   = st_max[c];
        r.cnt  = st_count[c];
        r.sum  = st_sum[c];
        r.occ  = st_oc[c];
        return r;
    endfunction

    // Applies one request word and queues the result word it causes.
    function automatic void predict_reading(req_t req, logic [3:0] ch, logic [11:0] raw);
        reading_t   r;
        logic [2:0] p;
        logic [11:0] avg;
        longint     cur;
        logic       oc;
        unique case (req)
            REQ_CLR_ALL: begin
                for (int c = 0; c < NCH; c++)
                    clear_channel(c);
                readings_q.push_back(stats_of(0, ch));
            end
            REQ_CLR_ONE: begin
                clear_channel(ch);
                readings_q.push_back(stats_of(ch, ch));
            end
            REQ_SAMPLE: begin
                p = win_ptr[ch];
                win_acc[ch] = win_acc[ch] - win_mem[ch][p] + raw;
                win_mem[ch][p] = raw;
                win_ptr[ch] = p + 3'd1;
                if (win_cnt[ch] < NWIN)
                    win_cnt[ch]++;
                avg = 12'(win_acc[ch] / win_cnt[ch]);
                cur = to_milliamps(avg);
                st_count[ch]++;
                st_sum[ch] = st_sum[ch] + cur;
                if (cur < longint'(st_min[ch]))
                    st_min[ch] = 32'(cur);
                if (cur > longint'(st_max[ch]))
                    st_max[ch] = 32'(cur);
                oc = (cur > longint'(cf_limit)) || (cur < -longint'(cf_limit));
                if (oc)
                    st_oc[ch]++;
                r = stats_of(ch, ch);
                r.cur  = 27'(cur);
                r.filt = avg;
                r.oc   = oc;
                readings_q.push_back(r);
            end
            default: ;
        endcase
    endfunction

    initial mismatches = 0;

    // Reset, register writes, request words and result words, edge by edge.
    always @(posedge aclk) begin
        reading_t e;
        if (!aresetn) begin
            cf_offset    <= 12'd0;
            cf_gain      <= 18'd65536;
            cf_sens      <= 10'd4;
            cf_limit     <= 26'd500000;
            cf_zero      <= 13'd1650;
            cf_ref       <= 13'd3300;
            cf_cal_valid <= 1'b0;
            for (int c = 0; c < NCH; c++) begin
                for (int k = 0; k < NWIN; k++)
                    win_mem[c][k] = '0;
                win_acc[c] = '0;
                win_cnt[c] = '0;
                win_ptr[c] = '0;
                clear_channel(c);
            end
            readings_q.delete();
        end else begin
            if (cfg_wr_en) begin
                unique case (reg_idx_t'(cfg_index))
                    REG_OFFSET_RAW:  cf_offset    <= cfg_wr_data[11:0];
                    REG_GAIN_FACTOR: cf_gain      <= cfg_wr_data[17:0];
                    REG_SENSITIVITY: cf_sens      <= cfg_wr_data[9:0];
                    REG_CUR_LIMIT:   cf_limit     <= cfg_wr_data[25:0];
                    REG_ZERO_MV:     cf_zero      <= cfg_wr_data[12:0];
                    REG_REFERENCE:   cf_ref       <= cfg_wr_data[12:0];
                    REG_CAL_VALID:   cf_cal_valid <= cfg_wr_data[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (readings_q.size() == 0) begin
                    report_mismatch("word with nothing due", '0, '0);
                end else begin
                    e = readings_q.pop_front();
                    if (m_channel_out !== e.ch)
                        report_mismatch("channel_out", m_channel_out, e.ch);
                    if (m_current_milliamps !== e.cur)
                        report_mismatch("current", m_current_milliamps, e.cur);
                    if (m_filtered_raw !== e.filt)
                        report_mismatch("filtered_raw", m_filtered_raw, e.filt);
                    if (m_overcurrent !== e.oc)
                        report_mismatch("overcurrent", m_overcurrent, e.oc);
                    if (m_min_current_milliamps !== e.mn)
                        report_mismatch("min_current", m_min_current_milliamps, e.mn);
                    if (m_max_current_milliamps !== e.mx)
                        report_mismatch("max_current", m_max_current_milliamps, e.mx);
                    if (m_sample_count !== e.cnt)
                        report_mismatch("sample_count", m_sample_count, e.cnt);
                    if (m_current_sum_ma !== e.sum)
                        report_mismatch("current_sum", m_current_sum_ma, e.sum);
                    if (m_overcurrent_count !== e.occ)
                        report_mismatch("overcurrent_count", m_overcurrent_count, e.occ);
                end
            end
            if (s_valid && s_ready)
                predict_reading(req_t'(s_req_type), s_channel, s_raw_sample);
        end
    end

endmodule

FILE: bench/tb_current_sense_channel_conditioner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Current sense conditioner testbench
// Drives directed and random request words through several register settings,
// with random gaps on both channels and one long receiver stall. The checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_current_sense_channel_conditioner_core;
    import cscc_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 300;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [2:0]         cfg_index;
    logic [25:0]        cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_req_type;
    logic [3:0]         s_channel;
    logic [11:0]        s_raw_sample;
    logic               m_valid;
    logic               m_ready;
    logic [3:0]         m_channel_out;
    logic signed [26:0] m_current_milliamps;
    logic [11:0]        m_filtered_raw;
    logic               m_overcurrent;
    logic signed [31:0] m_min_current_milliamps;
    logic signed [31:0] m_max_current_milliamps;
    logic [31:0]        m_sample_count;
    logic signed [63:0] m_current_sum_ma;
    logic [31:0]        m_overcurrent_count;

    int mismatches;
    int readings_due;
    int cycles;
    bit idle_on;
    bit hold_req;

    current_sense_channel_conditioner_core dut (.*);
    conditioner_checker checker_i (.*);

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Run limit.
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver: random stalls, and one long hold-off when asked for.
    initial begin
        m_ready <= 1'b0;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (3000) @(posedge aclk);
            end else begin
                m_ready <= !idle_on || ($urandom_range(99) >= 16);
                @(posedge aclk);
            end
        end
    end

    // Offers one word and waits for it to be taken.
    task automatic send_word(input req_t r, input logic [3:0] c, input logic [11:0] x);
        if (idle_on && $urandom_range(99) < 16) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 40);
        end
        s_valid      <= 1'b1;
        s_req_type   <= r;
        s_channel    <= c;
        s_raw_sample <= x;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Lets every due word arrive, then the block settle.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (readings_due == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [25:0] d);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= d;
        @(posedge aclk);
    endtask

    task automatic set_config(input int ofs, input int gain, input int sens,
                              input int lim, input int zero, input int vref,
                              input int cal);
        write_reg(REG_OFFSET_RAW, 26'(ofs));
        write_reg(REG_GAIN_FACTOR, 26'(gain));
        write_reg(REG_SENSITIVITY, 26'(sens));
        write_reg(REG_CUR_LIMIT, 26'(lim));
        write_reg(REG_ZERO_MV, 26'(zero));
        write_reg(REG_REFERENCE, 26'(vref));
        write_reg(REG_CAL_VALID, 26'(cal));
        write_reg(REG_UNUSED, 26'($urandom));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Random words, mostly samples; span narrows the channels to fill windows.
    task automatic send_random(input int words, input int span, input bit with_hold);
        int   pick;
        int   sent;
        req_t r;
        logic [11:0] x;
        sent = 0;
        while (sent < words) begin
            pick = $urandom_range(99);
            r = (pick < 82) ? REQ_SAMPLE : (pick < 89) ? REQ_CLR_ONE :
                (pick < 93) ? REQ_CLR_ALL : REQ_UNDEFINED;
            pick = $urandom_range(99);
            x = (pick < 5) ? 12'h000 : (pick < 10) ? 12'hFFF : 12'($urandom);
            send_word(r, 4'($urandom_range(0, span - 1)), x);
            sent++;
            if (with_hold && sent == 40)
                hold_req = 1'b1;
        end
    endtask

    initial begin
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= REG_OFFSET_RAW;
        cfg_wr_data  <= '0;
        s_valid      <= 1'b0;
        s_req_type   <= REQ_SAMPLE;
        s_channel    <= '0;
        s_raw_sample <= '0;
        idle_on      = 1'b1;
        hold_req     = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Calibration not yet valid: currents are forced to zero.
        send_word(REQ_SAMPLE, 4'd0, 12'hFFF);
        send_word(REQ_SAMPLE, 4'd15, 12'h000);
        drain();

        // Default scaling with calibration on; window fill and wrap.
        set_config(0, 65536, 4, 500000, 1650, 3300, 1);
        send_word(REQ_SAMPLE, 4'd3, 12'h000);
        send_word(REQ_SAMPLE, 4'd3, 12'hFFF);
        for (int k = 0; k < 8; k++)
            send_word(REQ_SAMPLE, 4'd3, 12'hA5A);
        send_word(REQ_SAMPLE, 4'd15, 12'hFFF);
        send_word(REQ_UNDEFINED, 4'd3, 12'h123);
        send_word(REQ_CLR_ONE, 4'd3, 12'h000);
        send_word(REQ_SAMPLE, 4'd3, 12'h800);
        send_word(REQ_CLR_ALL, 4'd9, 12'hFFF);
        send_word(REQ_CLR_ONE, 4'd15, 12'hFFF);
        drain();

        // Extremes: largest offset and gain, a reference of 5000, zero limit.
        set_config(4095, 262143, 1, 0, 5000, 5000, 1);
        send_word(REQ_SAMPLE, 4'd1, 12'h000);
        send_word(REQ_SAMPLE, 4'd2, 12'hFFF);
        drain();

        // Zero sensitivity is taken as one; largest limit.
        set_config(0, 262143, 0, 67108863, 0, 5000, 1);
        send_word(REQ_SAMPLE, 4'd1, 12'hFFF);
        send_word(REQ_SAMPLE, 4'd4, 12'h7FF);
        drain();

        // Random phases over default, zero gain and random settings.
        set_config(0, 65536, 4, 500000, 1650, 3300, 1);
        send_random(220, 16, 1'b1);
        drain();

        set_config(2048, 0, 1000, 0, 2500, 1, 1);
        send_random(120, 4, 1'b0);
        drain();

        // A stretch with no idling on either side.
        idle_on = 1'b0;
        set_config($urandom_range(0, 4095), $urandom_range(0, 262143),
                   $urandom_range(1, 1000), $urandom_range(0, 2000000),
                   $urandom_range(0, 5000), $urandom_range(1, 5000), 1);
        send_random(250, 16, 1'b0);
        drain();
        idle_on = 1'b1;

        set_config($urandom_range(0, 4095), $urandom_range(0, 262143), 1,
                   $urandom_range(0, 67108863), $urandom_range(0, 5000),
                   $urandom_range(1, 5000), 0);
        send_random(120, 16, 1'b0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            set_config($urandom_range(0, 4095), $urandom_range(0, 262143),
                       $urandom_range(1, 1000), $urandom_range(0, 3000000),
                       $urandom_range(0, 5000), $urandom_range(1, 5000), 1);
            send_random(185, (ph % 2) ? 3 : 16, 1'b0);
            drain();
        end

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
hdl/cscc_pkg.sv
hdl/cscc_div.sv
hdl/cscc_window.sv
hdl/current_sense_channel_conditioner_core.sv
bench/conditioner_checker.sv
bench/tb_current_sense_channel_conditioner_core.sv
